/* hdl/tssc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tssc_pkg;

    // Configuration port.
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMPO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPP   = 2'd2;

    localparam int TEMPO_W = 9;
    localparam logic [TEMPO_W-1:0] TEMPO_MAX   = 9'd300;
    localparam logic [TEMPO_W-1:0] TEMPO_RESET = 9'd120;
    localparam int TRACK_RAW_W = 7;
    localparam int TRACK_RESET = 16;
    localparam int SPP_W = 5;
    localparam logic [SPP_W-1:0] SPP_MAX   = 5'd16;
    localparam logic [SPP_W-1:0] SPP_RESET = 5'd4;

    // Request codes.
    localparam int REQ_W = 3;
    localparam logic [REQ_W-1:0] REQ_TICK     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_FORWARD  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_BACKWARD = 3'd2;
    localparam logic [REQ_W-1:0] REQ_PAUSE    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_RESET    = 3'd4;
    localparam logic [REQ_W-1:0] REQ_SET_STEP = 3'd5;

    // Run modes.
    localparam int DIR_W = 2;
    localparam logic [DIR_W-1:0] DIR_PAUSED   = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FORWARD  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_BACKWARD = 2'd2;

    localparam int TICK_W      = 16;
    localparam int SV_W        = 6;
    localparam int OUT_STEP_W  = 6;
    localparam int OUT_PULSE_W = 6;
    localparam int ELAPSED_W   = 32;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    // Shared divider.
    localparam int DIV_DW     = 26;
    localparam int DIV_VW     = 13;
    localparam int DIV_CNT_W  = 5;
    localparam int PROD_W     = 13;
    localparam logic [DIV_DW-1:0] MINUTE_US = 26'd60000000;
    localparam logic [DIV_DW-1:0] LEN_RESET = 26'd125000;

    typedef struct packed {
        logic accept;
        logic exec;
        logic check;
        logic div_len;
        logic div_mod;
        logic div_pulse;
        logic wr_len;
        logic wr_mod;
        logic wr_pulse;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic len_dirty;
        logic is_tick;
        logic step_due;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

/* hdl/tssc_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module tssc_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [tssc_pkg::DIV_DW-1:0]      dividend,
    input  logic [tssc_pkg::DIV_VW-1:0]      divisor,
    input  logic [tssc_pkg::DIV_CNT_W-1:0]   count,
    output logic [tssc_pkg::DIV_DW-1:0]      quo,
    output logic [tssc_pkg::DIV_VW-1:0]      rem,
    output logic                             done
);

    logic [tssc_pkg::DIV_DW-1:0]    quo_reg, quo_next;
    logic [tssc_pkg::DIV_VW-1:0]    rem_reg, rem_next;
    logic [tssc_pkg::DIV_VW-1:0]    dvs_reg, dvs_next;
    logic [tssc_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [tssc_pkg::DIV_VW:0]      trial;
    logic [tssc_pkg::DIV_VW:0]      diff;
    logic                           fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[tssc_pkg::DIV_DW-1]};
        diff      = trial - {1'b0, dvs_reg};
        fits      = (trial >= {1'b0, dvs_reg});
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = count;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[tssc_pkg::DIV_VW-1:0] : trial[tssc_pkg::DIV_VW-1:0];
            quo_next = {quo_reg[tssc_pkg::DIV_DW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == tssc_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quo  = quo_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

/* hdl/tssc_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module tssc_dp #(
    parameter int MAX_STEPS = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [tssc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tssc_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic [tssc_pkg::IN_TDATA_W-1:0]      in_data,
    input  logic [tssc_pkg::REQ_W-1:0]           in_req,
    output logic [tssc_pkg::OUT_TDATA_W-1:0]     out_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    input  tssc_pkg::cmd_t                       cmd,
    output tssc_pkg::stat_t                      st
);

    localparam int SW = $clog2(MAX_STEPS);
    localparam int TW = $clog2(MAX_STEPS + 1);
    localparam int NW = SW + 1;
    localparam logic [8:0] MAX_V = 9'(MAX_STEPS);
    localparam logic [TW-1:0] TRACK_INIT =
        TW'((MAX_STEPS < tssc_pkg::TRACK_RESET) ? MAX_STEPS : tssc_pkg::TRACK_RESET);

    // Configuration registers.
    logic [tssc_pkg::TEMPO_W-1:0] tempo_reg, tempo_next;
    logic [TW-1:0]                track_reg, track_next;
    logic [tssc_pkg::SPP_W-1:0]   spp_reg, spp_next;
    logic [tssc_pkg::DIV_DW-1:0]  len_reg, len_next;
    logic                         dirty_reg, dirty_next;

    // Captured input word.
    logic [tssc_pkg::REQ_W-1:0]   in_req_reg;
    logic [tssc_pkg::TICK_W-1:0]  in_tick_reg;
    logic [tssc_pkg::SV_W-1:0]    in_sv_reg;
    logic                         in_clr_reg;

    // Clock state.
    logic [SW-1:0]                    step_reg, step_next;
    logic [tssc_pkg::ELAPSED_W-1:0]   elapsed_reg, elapsed_next;
    logic [tssc_pkg::ELAPSED_W-1:0]   saved_reg, saved_next;
    logic [tssc_pkg::DIR_W-1:0]       dir_reg, dir_next;
    logic                             flag_step_reg, flag_step_next;
    logic                             flag_seq_reg, flag_seq_next;
    logic                             flag_pulse_reg, flag_pulse_next;
    logic                             stepped_reg, stepped_next;
    logic [NW-1:0]                    npos_reg, npos_next;
    logic [tssc_pkg::OUT_PULSE_W-1:0] pulse_reg, pulse_next;
    logic                             out_valid_reg, out_valid_next;
    logic [tssc_pkg::OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    // Combinational helpers.
    logic [tssc_pkg::TEMPO_W-1:0]     tempo_clamp;
    logic [8:0]                       track_raw;
    logic [8:0]                       track_clamp;
    logic [tssc_pkg::SPP_W-1:0]       spp_clamp;
    logic [tssc_pkg::PROD_W-1:0]      prod;
    logic [tssc_pkg::ELAPSED_W:0]     elapsed_sum;
    logic [tssc_pkg::ELAPSED_W-1:0]   elapsed_sat;
    logic [tssc_pkg::ELAPSED_W-1:0]   len_ext;
    logic                             step_due;
    logic [8:0]                       sv_ext;
    logic [8:0]                       sv_lim;
    logic [8:0]                       sv_pick;

    logic                             div_start;
    logic [tssc_pkg::DIV_DW-1:0]      div_dividend;
    logic [tssc_pkg::DIV_VW-1:0]      div_divisor;
    logic [tssc_pkg::DIV_CNT_W-1:0]   div_count;
    logic [tssc_pkg::DIV_DW-1:0]      div_quo;
    logic [tssc_pkg::DIV_VW-1:0]      div_rem;
    logic                             div_done;

    tssc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .count    (div_count),
        .quo      (div_quo),
        .rem      (div_rem),
        .done     (div_done)
    );

    always_comb
    begin
        tempo_clamp = cfg_wdata[tssc_pkg::TEMPO_W-1:0];
        if (tempo_clamp == '0)
        begin
            tempo_clamp = tssc_pkg::TEMPO_W'(1);
        end
        else if (tempo_clamp > tssc_pkg::TEMPO_MAX)
        begin
            tempo_clamp = tssc_pkg::TEMPO_MAX;
        end

        track_raw   = {2'b00, cfg_wdata[tssc_pkg::TRACK_RAW_W-1:0]};
        track_clamp = track_raw;
        if (track_raw == '0)
        begin
            track_clamp = 9'd1;
        end
        else if (track_raw > MAX_V)
        begin
            track_clamp = MAX_V;
        end

        spp_clamp = cfg_wdata[tssc_pkg::SPP_W-1:0];
        if (spp_clamp == '0)
        begin
            spp_clamp = tssc_pkg::SPP_W'(1);
        end
        else if (spp_clamp > tssc_pkg::SPP_MAX)
        begin
            spp_clamp = tssc_pkg::SPP_MAX;
        end
    end

    assign prod = tssc_pkg::PROD_W'(tempo_reg) * tssc_pkg::PROD_W'(spp_reg);

    always_comb
    begin
        div_start = cmd.div_len | cmd.div_mod | cmd.div_pulse;
        priority if (cmd.div_len)
        begin
            div_dividend = tssc_pkg::MINUTE_US;
            div_divisor  = prod[tssc_pkg::DIV_VW-1:0];
            div_count    = tssc_pkg::DIV_CNT_W'(tssc_pkg::DIV_DW);
        end
        else if (cmd.div_mod)
        begin
            div_dividend = {npos_reg, {(tssc_pkg::DIV_DW - NW){1'b0}}};
            div_divisor  = tssc_pkg::DIV_VW'(track_reg);
            div_count    = tssc_pkg::DIV_CNT_W'(NW);
        end
        else
        begin
            div_dividend = {NW'(step_reg), {(tssc_pkg::DIV_DW - NW){1'b0}}};
            div_divisor  = tssc_pkg::DIV_VW'(spp_reg);
            div_count    = tssc_pkg::DIV_CNT_W'(NW);
        end
    end

    always_comb
    begin
        elapsed_sum = {1'b0, elapsed_reg} + (tssc_pkg::ELAPSED_W + 1)'(in_tick_reg);
        elapsed_sat = elapsed_sum[tssc_pkg::ELAPSED_W] ? '1
                                                        : elapsed_sum[tssc_pkg::ELAPSED_W-1:0];
        len_ext     = tssc_pkg::ELAPSED_W'(len_reg);
        step_due    = (dir_reg != tssc_pkg::DIR_PAUSED) && (elapsed_reg >= len_ext);
        sv_ext      = 9'(in_sv_reg);
        sv_lim      = 9'(track_reg) - 9'd1;
        sv_pick     = (sv_ext > sv_lim) ? sv_lim : sv_ext;
    end

    always_comb
    begin
        tempo_next      = tempo_reg;
        track_next      = track_reg;
        spp_next        = spp_reg;
        len_next        = len_reg;
        dirty_next      = dirty_reg;
        step_next       = step_reg;
        elapsed_next    = elapsed_reg;
        saved_next      = saved_reg;
        dir_next        = dir_reg;
        flag_step_next  = flag_step_reg;
        flag_seq_next   = flag_seq_reg;
        flag_pulse_next = flag_pulse_reg;
        stepped_next    = stepped_reg;
        npos_next       = npos_reg;
        pulse_next      = pulse_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg & ~out_ready;

        if (cmd.div_len)
        begin
            dirty_next = 1'b0;
        end
        if (cfg_we)
        begin
            unique case (cfg_index)
                tssc_pkg::CFG_TEMPO:
                begin
                    tempo_next = tempo_clamp;
                    dirty_next = 1'b1;
                end
                tssc_pkg::CFG_TRACK:
                begin
                    track_next = track_clamp[TW-1:0];
                    dirty_next = 1'b1;
                end
                tssc_pkg::CFG_SPP:
                begin
                    spp_next   = spp_clamp;
                    dirty_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.wr_len)
        begin
            len_next = div_quo;
        end

        if (cmd.exec)
        begin
            stepped_next = 1'b0;
            unique case (in_req_reg)
                tssc_pkg::REQ_TICK:
                begin
                    elapsed_next    = elapsed_sat;
                    flag_step_next  = 1'b0;
                    flag_seq_next   = 1'b0;
                    flag_pulse_next = 1'b0;
                end
                tssc_pkg::REQ_FORWARD,
                tssc_pkg::REQ_BACKWARD:
                begin
                    if (dir_reg == tssc_pkg::DIR_PAUSED)
                    begin
                        elapsed_next = saved_reg;
                    end
                    dir_next = (in_req_reg == tssc_pkg::REQ_FORWARD) ? tssc_pkg::DIR_FORWARD
                                                                     : tssc_pkg::DIR_BACKWARD;
                end
                tssc_pkg::REQ_PAUSE:
                begin
                    saved_next = elapsed_reg;
                    dir_next   = tssc_pkg::DIR_PAUSED;
                end
                tssc_pkg::REQ_RESET:
                begin
                    step_next      = '0;
                    elapsed_next   = '0;
                    flag_step_next = 1'b1;
                    flag_seq_next  = 1'b1;
                end
                tssc_pkg::REQ_SET_STEP:
                begin
                    step_next = sv_pick[SW-1:0];
                    if (in_clr_reg)
                    begin
                        elapsed_next = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.check)
        begin
            elapsed_next   = elapsed_reg - len_ext;
            flag_step_next = 1'b1;
            stepped_next   = 1'b1;
            if (dir_reg == tssc_pkg::DIR_FORWARD)
            begin
                npos_next = NW'(step_reg) + NW'(1);
            end
            else if (step_reg == '0)
            begin
                npos_next = NW'(track_reg) - NW'(1);
            end
            else
            begin
                npos_next = NW'(step_reg) - NW'(1);
            end
        end

        if (cmd.wr_mod)
        begin
            step_next = div_rem[SW-1:0];
        end

        if (cmd.wr_pulse)
        begin
            pulse_next = div_quo[tssc_pkg::OUT_PULSE_W-1:0];
            if (stepped_reg)
            begin
                flag_seq_next   = (step_reg == '0);
                flag_pulse_next = (div_rem == '0);
            end
        end

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = tssc_pkg::OUT_TDATA_W'({dir_reg, flag_pulse_reg, flag_seq_reg,
                                                     flag_step_reg, pulse_reg,
                                                     tssc_pkg::OUT_STEP_W'(step_reg)});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tempo_reg      <= tssc_pkg::TEMPO_RESET;
            track_reg      <= TRACK_INIT;
            spp_reg        <= tssc_pkg::SPP_RESET;
            len_reg        <= tssc_pkg::LEN_RESET;
            dirty_reg      <= 1'b0;
            step_reg       <= '0;
            elapsed_reg    <= '0;
            saved_reg      <= '0;
            dir_reg        <= tssc_pkg::DIR_PAUSED;
            flag_step_reg  <= 1'b0;
            flag_seq_reg   <= 1'b0;
            flag_pulse_reg <= 1'b0;
            stepped_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            tempo_reg      <= tempo_next;
            track_reg      <= track_next;
            spp_reg        <= spp_next;
            len_reg        <= len_next;
            dirty_reg      <= dirty_next;
            step_reg       <= step_next;
            elapsed_reg    <= elapsed_next;
            saved_reg      <= saved_next;
            dir_reg        <= dir_next;
            flag_step_reg  <= flag_step_next;
            flag_seq_reg   <= flag_seq_next;
            flag_pulse_reg <= flag_pulse_next;
            stepped_reg    <= stepped_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            in_req_reg  <= in_req;
            in_tick_reg <= in_data[15:0];
            in_sv_reg   <= in_data[21:16];
            in_clr_reg  <= in_data[22];
        end
        npos_reg     <= npos_next;
        pulse_reg    <= pulse_next;
        out_data_reg <= out_data_next;
    end

    assign out_data    = out_data_reg;
    assign out_valid   = out_valid_reg;
    assign st.div_done  = div_done;
    assign st.len_dirty = dirty_reg;
    assign st.is_tick   = (in_req_reg == tssc_pkg::REQ_TICK);
    assign st.step_due  = step_due;
    assign st.out_free  = ~out_valid_reg | out_ready;

    a_pos_in_track: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_mod |=> (TW'(step_reg) < track_reg))
        else $error("step position left the track after wrap");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten while a word was pending");

endmodule

`default_nettype wire

/* hdl/tssc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module tssc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  tssc_pkg::stat_t st,
    output tssc_pkg::cmd_t  cmd
);

    typedef enum logic [8:0] {
        ST_IDLE       = 9'b000000001,
        ST_LEN_WAIT   = 9'b000000010,
        ST_EXEC       = 9'b000000100,
        ST_ADV        = 9'b000001000,
        ST_MOD_GO     = 9'b000010000,
        ST_MOD_WAIT   = 9'b000100000,
        ST_PULSE_GO   = 9'b001000000,
        ST_PULSE_WAIT = 9'b010000000,
        ST_DONE       = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (st.len_dirty)
                begin
                    cmd.div_len = 1'b1;
                    state_next  = ST_LEN_WAIT;
                end
                else
                begin
                    in_ready = 1'b1;
                    if (in_valid)
                    begin
                        cmd.accept = 1'b1;
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_LEN_WAIT:
            begin
                if (st.div_done)
                begin
                    cmd.wr_len = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = st.is_tick ? ST_ADV : ST_PULSE_GO;
            end
            ST_ADV:
            begin
                if (st.step_due)
                begin
                    cmd.check  = 1'b1;
                    state_next = ST_MOD_GO;
                end
                else
                begin
                    state_next = ST_PULSE_GO;
                end
            end
            ST_MOD_GO:
            begin
                cmd.div_mod = 1'b1;
                state_next  = ST_MOD_WAIT;
            end
            ST_MOD_WAIT:
            begin
                if (st.div_done)
                begin
                    cmd.wr_mod = 1'b1;
                    state_next = ST_PULSE_GO;
                end
            end
            ST_PULSE_GO:
            begin
                cmd.div_pulse = 1'b1;
                state_next    = ST_PULSE_WAIT;
            end
            ST_PULSE_WAIT:
            begin
                if (st.div_done)
                begin
                    cmd.wr_pulse = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted word did not enter execution");

    a_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        st.div_done |-> (state_reg == ST_LEN_WAIT || state_reg == ST_MOD_WAIT ||
                         state_reg == ST_PULSE_WAIT))
        else $error("divider finished while no state was waiting for it");

endmodule

`default_nettype wire

/* hdl/tempo_step_sequencer_clock.sv */
`timescale 1ns / 1ps
`default_nettype none

// Step clock for a looping music sequencer. Each input word is a request (tick, forward,
// backward, pause, reset or set step) and produces exactly one output word with the step
// position, the pulse index and the step, sequence-start and pulse flags. The shared
// one-bit-per-cycle divider finds the pulse index and, after a step, the track wrap.
// After a write to the tempo, track-length or steps-per-pulse register, the next word
// waits while the same divider recomputes the step length. The next word is taken while an
// output word is still waiting to be read.
module tempo_step_sequencer_clock #(
    parameter int MAX_STEPS = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [tssc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tssc_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tick_us, step_value, clear_time
    input  logic [tssc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // req_type
    input  logic [tssc_pkg::REQ_W-1:0]           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // step_now, pulse_now, step_moved, sequence_start, pulse_hit, run_mode
    output logic [tssc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    tssc_pkg::cmd_t  cmd;
    tssc_pkg::stat_t st;

    tssc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    tssc_dp #(
        .MAX_STEPS (MAX_STEPS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_axis_tdata),
        .in_req    (s_axis_tuser),
        .out_data  (m_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

`default_nettype wire

/* verif/tb_tempo_step_sequencer_clock.sv */
`timescale 1ns / 1ps

module tb_tempo_step_sequencer_clock;

    import tssc_pkg::*;

    localparam int TRACK_MAX = 64;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_WORDS = 190;
    localparam int SLOW_TICKS = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;
    localparam int F_STEP = 0;
    localparam int F_SEQ = 1;
    localparam int F_PULSE = 2;

    typedef struct {
        logic [REQ_W-1:0]  req;
        logic [TICK_W-1:0] tick_us;
        logic [SV_W-1:0]   step_value;
        logic              clear_time;
    } clock_request_t;

    typedef struct {
        logic [OUT_STEP_W-1:0]  step_now;
        logic [OUT_PULSE_W-1:0] pulse_now;
        logic                   step_moved;
        logic                   sequence_start;
        logic                   pulse_hit;
        logic [DIR_W-1:0]       run_mode;
    } step_report_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [REQ_W-1:0]       s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    clock_request_t pending_requests[$];
    step_report_t   expected_reports[$];
    int             mismatch_count = 0;
    int             idle_cycles = 0;
    logic           word_taken = 1'b0;
    bit             steady = 1'b0;
    int             gap_left = 0;
    int             burst_left = 0;
    logic [15:0]    ready_pattern = '1;
    int             ready_age = 0;
    logic [3:0]     ready_phase = '0;

    int unsigned    tempo_m = TEMPO_RESET;
    int unsigned    track_m = TRACK_RESET;
    int unsigned    spp_m = SPP_RESET;
    int unsigned    step_len_m = LEN_RESET;
    int unsigned    step_m = 0;
    logic [31:0]    elapsed_m = '0;
    logic [31:0]    saved_m = '0;
    logic [DIR_W-1:0] dir_m = DIR_PAUSED;
    logic [2:0]     flags_m = '0;

    tempo_step_sequencer_clock #(
        .MAX_STEPS(TRACK_MAX)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int unsigned bound(input int unsigned v, input int unsigned lo,
                                          input int unsigned hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic void load_register(input logic [CFG_IDX_W-1:0] idx,
                                          input int unsigned value);
        case (idx)
            CFG_TEMPO: tempo_m = bound(value & 'h1FF, 1, TEMPO_MAX);
            CFG_TRACK: track_m = bound(value & 'h7F, 1, TRACK_MAX);
            CFG_SPP:   spp_m = bound(value & 'h1F, 1, SPP_MAX);
            default:   return;
        endcase
        step_len_m = MINUTE_US / (tempo_m * spp_m);
    endfunction

    function automatic step_report_t clock_after(input clock_request_t r);
        step_report_t rep;
        logic [32:0] sum;
        case (r.req)
            REQ_TICK:
            begin
                sum = {1'b0, elapsed_m} + 33'(r.tick_us);
                elapsed_m = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                flags_m = '0;
                if (dir_m != DIR_PAUSED && elapsed_m >= step_len_m)
                begin
                    if (dir_m == DIR_FORWARD)
                        step_m = (step_m + 1) % track_m;
                    else if (step_m == 0)
                        step_m = track_m - 1;
                    else
                        step_m = (step_m - 1) % track_m;
                    elapsed_m = elapsed_m - step_len_m;
                    flags_m[F_STEP] = 1'b1;
                    flags_m[F_SEQ] = (step_m == 0);
                    flags_m[F_PULSE] = (step_m % spp_m == 0);
                end
            end
            REQ_FORWARD, REQ_BACKWARD:
            begin
                if (dir_m == DIR_PAUSED)
                    elapsed_m = saved_m;
                dir_m = (r.req == REQ_FORWARD) ? DIR_FORWARD : DIR_BACKWARD;
            end
            REQ_PAUSE:
            begin
                saved_m = elapsed_m;
                dir_m = DIR_PAUSED;
            end
            REQ_RESET:
            begin
                step_m = 0;
                elapsed_m = '0;
                flags_m[F_STEP] = 1'b1;
                flags_m[F_SEQ] = 1'b1;
            end
            REQ_SET_STEP:
            begin
                step_m = (r.step_value > track_m - 1) ? track_m - 1 : r.step_value;
                if (r.clear_time)
                    elapsed_m = '0;
            end
            default:
            begin
            end
        endcase
        rep.step_now = step_m[OUT_STEP_W-1:0];
        rep.pulse_now = OUT_PULSE_W'(step_m / spp_m);
        rep.step_moved = flags_m[F_STEP];
        rep.sequence_start = flags_m[F_SEQ];
        rep.pulse_hit = flags_m[F_PULSE];
        rep.run_mode = dir_m;
        return rep;
    endfunction

    function automatic clock_request_t random_request();
        clock_request_t r;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        r.step_value = SV_W'($urandom);
        r.clear_time = 1'($urandom);
        case ($urandom_range(0, 2))
            0:       r.tick_us = TICK_W'($urandom);
            1:       r.tick_us = TICK_W'($urandom_range(0, 255));
            default: r.tick_us = TICK_W'($urandom_range(20000, 65535));
        endcase
        if (pick < 68)
            r.req = REQ_TICK;
        else if (pick < 78)
            r.req = REQ_FORWARD;
        else if (pick < 84)
            r.req = REQ_BACKWARD;
        else if (pick < 89)
            r.req = REQ_PAUSE;
        else if (pick < 92)
            r.req = REQ_RESET;
        else if (pick < 98)
            r.req = REQ_SET_STEP;
        else
            r.req = $urandom_range(0, 1) ? REQ_SPARE_HI : REQ_SPARE_LO;
        return r;
    endfunction

    task automatic push_request(input logic [REQ_W-1:0] req, input int unsigned tick_us,
                                input int unsigned step_value, input bit clear_time);
        clock_request_t r;
        r.req = req;
        r.tick_us = TICK_W'(tick_us);
        r.step_value = SV_W'(step_value);
        r.clear_time = clear_time;
        pending_requests.push_back(r);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic drain();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (pending_requests.size() != 0 || s_axis_tvalid || expected_reports.size() != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_W-1:0];
        load_register(idx, value[CFG_W-1:0]);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int unsigned tempo, input int unsigned track,
                             input int unsigned spp, input bit no_idle);
        drain();
        write_register(CFG_TEMPO, tempo);
        write_register(CFG_TRACK, track);
        write_register(CFG_SPP, spp);
        @(posedge clk);
        steady = no_idle;
        for (int i = 0; i < PHASE_WORDS; i++)
            pending_requests.push_back(random_request());
    endtask

    // Sender: bursts of random length separated by random gaps, or by none while steady is set.
    always @(negedge clk)
    begin : driver
        clock_request_t w;
        logic next_valid;
        if (rst_n)
        begin
            next_valid = s_axis_tvalid && !word_taken;
            if (!next_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_requests.size() > 0)
                begin
                    w = pending_requests.pop_front();
                    s_axis_tdata <= {1'b0, w.clear_time, w.step_value, w.tick_us};
                    s_axis_tuser <= w.req;
                    next_valid = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 16);
                        gap_left = steady ? 0 : $urandom_range(0, 12);
                    end
                end
            end
            s_axis_tvalid <= next_valid;
        end
    end

    // Receiver: a rotating random ready pattern, redrawn when its age runs out; ready is held high while steady is set.
    always @(negedge clk)
    begin : receiver
        if (ready_age == 0)
        begin
            case ($urandom_range(0, 2))
                0:       ready_pattern = 16'($urandom & $urandom);
                1:       ready_pattern = 16'($urandom | $urandom);
                default: ready_pattern = 16'($urandom);
            endcase
            ready_pattern[$urandom_range(0, 15)] = 1'b1;
            ready_age = $urandom_range(16, 96);
        end
        ready_age--;
        m_axis_tready <= steady || ready_pattern[ready_phase];
        ready_phase <= ready_phase + 4'd1;
    end

    always @(posedge clk)
    begin : monitor
        clock_request_t r;
        step_report_t want;
        if (rst_n)
        begin
            word_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                r.req = s_axis_tuser;
                r.tick_us = s_axis_tdata[15:0];
                r.step_value = s_axis_tdata[21:16];
                r.clear_time = s_axis_tdata[22];
                expected_reports.push_back(clock_after(r));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("unexpected output word 0x%06h", m_axis_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("step_now", want.step_now, m_axis_tdata[5:0]);
                    check_field("pulse_now", want.pulse_now, m_axis_tdata[11:6]);
                    check_field("step_moved", want.step_moved, m_axis_tdata[12]);
                    check_field("sequence_start", want.sequence_start, m_axis_tdata[13]);
                    check_field("pulse_hit", want.pulse_hit, m_axis_tdata[14]);
                    check_field("run_mode", want.run_mode, m_axis_tdata[16:15]);
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: 125000 us per step, 16 steps, 4 steps per pulse.
        push_request(REQ_TICK, 16'hFFFF, 0, 0);
        push_request(REQ_TICK, 0, 6'h3F, 1);
        push_request(REQ_PAUSE, 0, 0, 0);
        push_request(REQ_PAUSE, 0, 0, 0);
        push_request(REQ_FORWARD, 0, 0, 0);
        push_request(REQ_TICK, 16'hFFFF, 0, 0);
        push_request(REQ_BACKWARD, 0, 0, 0);
        push_request(REQ_TICK, 16'hFFFF, 0, 0);
        push_request(REQ_TICK, 16'hFFFF, 0, 0);
        push_request(REQ_TICK, 16'hFFFF, 0, 0);
        push_request(REQ_TICK, 16'hFFFF, 0, 0);
        push_request(REQ_SET_STEP, 0, 6'h3F, 0);
        push_request(REQ_SET_STEP, 16'hFFFF, 8, 1);
        push_request(REQ_RESET, 0, 0, 0);
        push_request(REQ_SPARE_LO, 16'hA5A5, 6'h2A, 1);
        push_request(REQ_SPARE_HI, 16'h5A5A, 6'h15, 0);
        push_request(REQ_FORWARD, 0, 0, 0);
        push_request(REQ_SET_STEP, 0, 0, 1);
        push_request(REQ_TICK, 1, 0, 0);
        push_request(REQ_PAUSE, 0, 0, 0);
        push_request(REQ_TICK, 16'hFFFF, 0, 0);
        push_request(REQ_BACKWARD, 0, 0, 0);
        push_request(REQ_TICK, 16'hFFFF, 0, 0);

        // Slowest tempo: paused ticks build up a long elapsed time that pause and
        // forward carry over.
        drain();
        write_register(CFG_TEMPO, 0);
        write_register(CFG_TRACK, 127);
        write_register(CFG_SPP, 0);
        write_register(CFG_SPARE, 9'h1FF);
        @(posedge clk);
        steady = 1'b1;
        push_request(REQ_PAUSE, 0, 0, 0);
        for (int i = 0; i < SLOW_TICKS; i++)
            push_request(REQ_TICK, 16'hFFFF, 0, 0);
        push_request(REQ_PAUSE, 0, 0, 0);
        push_request(REQ_FORWARD, 0, 0, 0);
        for (int i = 0; i < 5; i++)
            push_request(REQ_TICK, 0, 0, 0);

        run_phase(511, 64, 31, 1'b0);
        run_phase(300, 5, 16, 1'b1);
        run_phase(240, 1, 1, 1'b0);
        run_phase(200, 64, 3, 1'b0);
        run_phase(300, 37, 7, 1'b0);
        run_phase(180, 0, 5, 1'b1);
        run_phase($urandom_range(200, 511), $urandom_range(0, 127), $urandom_range(0, 31),
                  1'b0);
        run_phase(TEMPO_RESET, TRACK_RESET, SPP_RESET, 1'b0);

        drain();
        repeat (50) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
